FILE: hdl/rfpc_pkg.sv
// Shared types, constants and functions for the response framer.
`timescale 1ns / 1ps

package rfpc_pkg;

    localparam int ByteW  = 8;
    localparam int CountW = 16;
    localparam int PopW   = 4;
    localparam int CfgIdxW = 8;
    localparam int PhaseW = 3;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegHeader = 8'd0;
    localparam logic [CfgIdxW-1:0] RegTail   = 8'd1;

    localparam logic [ByteW-1:0] HeaderReset = 8'd170;
    localparam logic [ByteW-1:0] TailReset   = 8'd99;

    // word positions within the run caused by one input word
    localparam logic [PhaseW-1:0] PhHdrA  = 3'd0;
    localparam logic [PhaseW-1:0] PhHdrB  = 3'd1;
    localparam logic [PhaseW-1:0] PhBody  = 3'd2;
    localparam logic [PhaseW-1:0] PhCntHi = 3'd3;
    localparam logic [PhaseW-1:0] PhCntLo = 3'd4;
    localparam logic [PhaseW-1:0] PhTail  = 3'd5;

    // pending body word plus what is needed to expand it
    typedef struct packed {
        logic                valid;
        logic [ByteW-1:0]    body_byte;
        logic                last;
        logic [CountW-1:0]   count;
        logic [PhaseW-1:0]   phase;
    } slot_t;

    // emit side feedback to the slot
    typedef struct packed {
        logic step;
        logic done;
    } emit_ctl_t;

    function automatic logic [PopW-1:0] pop8(input logic [ByteW-1:0] v);
        logic [PopW-1:0] n;
        n = '0;
        for (int k = 0; k < ByteW; k++)
        begin
            n = n + {{(PopW-1){1'b0}}, v[k]};
        end
        return n;
    endfunction

endpackage

FILE: hdl/rfpc_body_if.sv
// Body input channel interface.
`timescale 1ns / 1ps

interface rfpc_body_if;
    logic                       valid;
    logic                       ready;
    logic [rfpc_pkg::ByteW-1:0] body_byte;
    logic                       body_last;

    modport source (output valid, output body_byte, output body_last, input ready);
    modport sink (input valid, input body_byte, input body_last, output ready);
endinterface

FILE: hdl/rfpc_tx_if.sv
// Transmit output channel interface.
`timescale 1ns / 1ps

interface rfpc_tx_if;
    logic                       valid;
    logic                       ready;
    logic [rfpc_pkg::ByteW-1:0] tx_byte;
    logic                       run_last;
    logic                       frame_end;

    modport source (output valid, output tx_byte, output run_last, output frame_end,
                    input ready);
    modport sink (input valid, input tx_byte, input run_last, input frame_end,
                  output ready);
endinterface

FILE: hdl/rfpc_cfg_if.sv
// Configuration write channel interface.
`timescale 1ns / 1ps

interface rfpc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rfpc_pkg::CfgIdxW-1:0] index;
    logic [rfpc_pkg::ByteW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/rfpc_intake.sv
// Input register: frame state, ones count and the pending body word.
`timescale 1ns / 1ps

module rfpc_intake (
    input  logic                       clk,
    input  logic                       rst_n,
    rfpc_body_if.sink                  body,
    input  logic [rfpc_pkg::ByteW-1:0] header_value,
    input  rfpc_pkg::emit_ctl_t        ctl,
    output rfpc_pkg::slot_t            slot
);

    rfpc_pkg::slot_t                    slot_reg;
    rfpc_pkg::slot_t                    slot_next;
    logic                               in_frame_reg;
    logic                               in_frame_next;
    logic [rfpc_pkg::CountW-1:0]        count_reg;
    logic [rfpc_pkg::CountW-1:0]        count_next;
    logic [rfpc_pkg::CountW-1:0]        count_base;
    logic [rfpc_pkg::PopW-1:0]          hdr_pop;
    logic                               accept;

    assign body.ready = !slot_reg.valid || ctl.done;
    assign accept     = body.valid && body.ready;
    assign hdr_pop    = rfpc_pkg::pop8(header_value);

    // opening word reloads with both header bytes' ones
    assign count_base = in_frame_reg ? count_reg
                      : {{(rfpc_pkg::CountW-rfpc_pkg::PopW-1){1'b0}}, hdr_pop, 1'b0};

    always_comb
    begin
        count_next    = count_reg;
        in_frame_next = in_frame_reg;
        slot_next     = slot_reg;
        if (accept)
        begin
            count_next          = count_base + {{(rfpc_pkg::CountW-rfpc_pkg::PopW){1'b0}},
                                                rfpc_pkg::pop8(body.body_byte)};
            in_frame_next       = !body.body_last;
            slot_next.valid     = 1'b1;
            slot_next.body_byte = body.body_byte;
            slot_next.last      = body.body_last;
            slot_next.count     = count_next;
            slot_next.phase     = in_frame_reg ? rfpc_pkg::PhBody : rfpc_pkg::PhHdrA;
        end
        else if (ctl.done)
        begin
            slot_next.valid = 1'b0;
        end
        else if (ctl.step)
        begin
            slot_next.phase = slot_reg.phase + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            in_frame_reg   <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            slot_reg       <= slot_next;
            in_frame_reg   <= in_frame_next;
            count_reg      <= count_next;
        end
    end

    assign slot = slot_reg;

endmodule

FILE: hdl/rfpc_emit.sv
// Word selection and output register for the transmit channel.
`timescale 1ns / 1ps

module rfpc_emit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rfpc_pkg::slot_t            slot,
    input  logic [rfpc_pkg::ByteW-1:0] header_value,
    input  logic [rfpc_pkg::ByteW-1:0] tail_value,
    output rfpc_pkg::emit_ctl_t        ctl,
    rfpc_tx_if.source                  tx
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [rfpc_pkg::ByteW-1:0] byte_reg;
    logic [rfpc_pkg::ByteW-1:0] byte_next;
    logic                       run_last_reg;
    logic                       run_last_next;
    logic                       frame_end_reg;
    logic                       frame_end_next;
    logic [rfpc_pkg::PhaseW-1:0] end_phase;
    logic                       load;

    assign end_phase = slot.last ? rfpc_pkg::PhTail : rfpc_pkg::PhBody;
    assign load      = slot.valid && (!valid_reg || tx.ready);
    assign ctl.step  = load;
    assign ctl.done  = load && (slot.phase == end_phase);

    always_comb
    begin
        case (slot.phase)
            rfpc_pkg::PhHdrA:  byte_next = header_value;
            rfpc_pkg::PhHdrB:  byte_next = header_value;
            rfpc_pkg::PhBody:  byte_next = slot.body_byte;
            rfpc_pkg::PhCntHi: byte_next = slot.count[15:8];
            rfpc_pkg::PhCntLo: byte_next = slot.count[7:0];
            rfpc_pkg::PhTail:  byte_next = tail_value;
            default:           byte_next = slot.body_byte;
        endcase
        run_last_next  = slot.phase == end_phase;
        frame_end_next = slot.phase == rfpc_pkg::PhTail;
        valid_next     = load || (valid_reg && !tx.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg      <= byte_next;
            run_last_reg  <= run_last_next;
            frame_end_reg <= frame_end_next;
        end
    end

    assign tx.valid     = valid_reg;
    assign tx.tx_byte   = byte_reg;
    assign tx.run_last  = run_last_reg;
    assign tx.frame_end = frame_end_reg;

endmodule

FILE: hdl/response_framer_popcount_checksum.sv
// Path: a body word passes the pending-word register, then the tx output register, after
// the two header bytes if it opens a frame. Throughput: one body word per cycle while tx
// is ready; a frame's first word holds input for the header bytes, its last for count and
// tail. The single pending-word register feeding the tx output register sets the rate.
// Reset clears frame state, ones count and valid flags; header/tail go to 170 and 99.
`timescale 1ns / 1ps

module response_framer_popcount_checksum (
    input  logic       clk,
    input  logic       rst_n,
    rfpc_body_if.sink  body,
    rfpc_tx_if.source  tx,
    rfpc_cfg_if.sink   cfg
);

    logic [rfpc_pkg::ByteW-1:0] header_value_reg;
    logic [rfpc_pkg::ByteW-1:0] tail_value_reg;
    rfpc_pkg::slot_t            slot;
    rfpc_pkg::emit_ctl_t        ctl;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg <= rfpc_pkg::HeaderReset;
            tail_value_reg   <= rfpc_pkg::TailReset;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == rfpc_pkg::RegHeader)
            begin
                header_value_reg <= cfg.data;
            end
            if (cfg.index == rfpc_pkg::RegTail)
            begin
                tail_value_reg <= cfg.data;
            end
        end
    end

    rfpc_intake u_intake (
        .clk          (clk),
        .rst_n        (rst_n),
        .body         (body),
        .header_value (header_value_reg),
        .ctl          (ctl),
        .slot         (slot)
    );

    rfpc_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot         (slot),
        .header_value (header_value_reg),
        .tail_value   (tail_value_reg),
        .ctl          (ctl),
        .tx           (tx)
    );

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot.valid |-> (slot.phase <= rfpc_pkg::PhTail))
        else $error("slot phase out of range");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.frame_end |-> tx.run_last)
        else $error("frame end word not last of its run");

    a_nonlast_body: assert property (@(posedge clk) disable iff (!rst_n)
        slot.valid && !slot.last |-> (slot.phase <= rfpc_pkg::PhBody))
        else $error("trailer phase on a non-final body word");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done && !body.valid |=> !slot.valid)
        else $error("slot still held after its final word");

endmodule

FILE: sim/tb_top.sv
// Testbench for the response framer: randomized body stream, stalls and register writes.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [rfpc_pkg::CfgIdxW-1:0] RegUnusedLo = 8'd2;
    localparam logic [rfpc_pkg::CfgIdxW-1:0] RegUnusedHi = 8'hFF;

    typedef struct packed {
        logic [rfpc_pkg::ByteW-1:0] tx_byte;
        logic                       run_last;
        logic                       frame_end;
    } tx_word_t;

    typedef enum logic [1:0] {RxFull, RxHalf, RxSparse, RxPattern} rx_mode_t;

    class framer_scoreboard;
        tx_word_t                    pending_tx_q[$];
        logic [rfpc_pkg::ByteW-1:0]  header_val;
        logic [rfpc_pkg::ByteW-1:0]  tail_val;
        logic                        frame_open;
        logic [rfpc_pkg::CountW-1:0] ones_total;
        int                          errors;

        function new();
            header_val = rfpc_pkg::HeaderReset;
            tail_val   = rfpc_pkg::TailReset;
            frame_open = 1'b0;
            ones_total = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [rfpc_pkg::CfgIdxW-1:0] idx,
                                logic [rfpc_pkg::ByteW-1:0] data);
            if (idx == rfpc_pkg::RegHeader)
            begin
                header_val = data;
            end
            else if (idx == rfpc_pkg::RegTail)
            begin
                tail_val = data;
            end
        endfunction

        function void add_word(logic [rfpc_pkg::ByteW-1:0] b, logic rl, logic fe);
            tx_word_t w;
            w.tx_byte   = b;
            w.run_last  = rl;
            w.frame_end = fe;
            pending_tx_q.push_back(w);
        endfunction

        // expand one accepted body word into the tx words it causes
        function void note_body(logic [rfpc_pkg::ByteW-1:0] b, logic last);
            if (!frame_open)
            begin
                ones_total = rfpc_pkg::CountW'(2 * $countones(header_val));
                add_word(header_val, 1'b0, 1'b0);
                add_word(header_val, 1'b0, 1'b0);
                frame_open = 1'b1;
            end
            ones_total = ones_total + rfpc_pkg::CountW'($countones(b));
            add_word(b, !last, 1'b0);
            if (last)
            begin
                add_word(ones_total[15:8], 1'b0, 1'b0);
                add_word(ones_total[7:0], 1'b0, 1'b0);
                add_word(tail_val, 1'b1, 1'b1);
                frame_open = 1'b0;
            end
        endfunction

        function void check_tx(logic [rfpc_pkg::ByteW-1:0] b, logic rl, logic fe);
            tx_word_t w;
            if (pending_tx_q.size() == 0)
            begin
                $display("%0t: unexpected tx word %02h run_last %0b frame_end %0b",
                         $time, b, rl, fe);
                errors++;
                return;
            end
            w = pending_tx_q.pop_front();
            if (b !== w.tx_byte)
            begin
                $display("%0t: tx_byte expected %02h actual %02h", $time, w.tx_byte, b);
                errors++;
            end
            if (rl !== w.run_last)
            begin
                $display("%0t: run_last expected %0b actual %0b", $time, w.run_last, rl);
                errors++;
            end
            if (fe !== w.frame_end)
            begin
                $display("%0t: frame_end expected %0b actual %0b", $time, w.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rfpc_body_if body_ch();
    rfpc_tx_if   tx_ch();
    rfpc_cfg_if  cfg_ch();

    framer_scoreboard sb = new();

    int       burst_left = 1;
    rx_mode_t rx_mode    = RxFull;
    logic [7:0] rx_mask  = 8'hFF;
    int       rx_left    = 0;

    response_framer_popcount_checksum dut (
        .clk   (clk),
        .rst_n (rst_n),
        .body  (body_ch),
        .tx    (tx_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // valid stays high across back-to-back words; it drops only for gaps and drains
    task automatic send_body(input logic [rfpc_pkg::ByteW-1:0] b, input logic last);
        body_ch.valid     <= 1'b1;
        body_ch.body_byte <= b;
        body_ch.body_last <= last;
        @(posedge clk);
        while (!body_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_body(b, last);
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                body_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 14);
        end
    endtask

    task automatic drain_tx();
        body_ch.valid <= 1'b0;
        while (sb.pending_tx_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [rfpc_pkg::CfgIdxW-1:0] idx,
                             input logic [rfpc_pkg::ByteW-1:0] data,
                             input bit hold);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, data);
        if (!hold)
        begin
            cfg_ch.valid <= 1'b0;
        end
    endtask

    // split_at > 0: drain and rewrite both registers after that many words, unless it is the last
    task automatic send_frame(input int len, input int split_at);
        logic [rfpc_pkg::ByteW-1:0] b;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            else
            begin
                b = rfpc_pkg::ByteW'($urandom);
            end
            send_body(b, i == len - 1);
            if (i + 1 == split_at && i != len - 1)
            begin
                drain_tx();
                cfg_write(rfpc_pkg::RegHeader, rfpc_pkg::ByteW'($urandom), 1'b1);
                cfg_write(rfpc_pkg::RegTail, rfpc_pkg::ByteW'($urandom), 1'b0);
            end
        end
    endtask

    initial
    begin
        tx_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && tx_ch.valid && tx_ch.ready)
            begin
                sb.check_tx(tx_ch.tx_byte, tx_ch.run_last, tx_ch.frame_end);
            end
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mask = 8'($urandom) | 8'h01;
                rx_left = $urandom_range(20, 80);
            end
            rx_left--;
            rx_mask = {rx_mask[6:0], rx_mask[7]};
            case (rx_mode)
                RxFull:   tx_ch.ready <= 1'b1;
                RxHalf:   tx_ch.ready <= 1'($urandom_range(0, 1));
                RxSparse: tx_ch.ready <= ($urandom_range(0, 3) == 0);
                default:  tx_ch.ready <= rx_mask[0];
            endcase
        end
    end

    initial
    begin
        #2_000_000;
        $display("[response_framer_popcount_checksum] ERROR");
        $finish;
    end

    initial
    begin
        int sent;
        int len;
        rst_n             <= 1'b0;
        body_ch.valid     <= 1'b0;
        body_ch.body_byte <= '0;
        body_ch.body_last <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, a single-word frame then a four-word frame
        send_body(8'h00, 1'b1);
        send_body(8'hFF, 1'b0);
        send_body(8'h00, 1'b0);
        send_body(8'h80, 1'b0);
        send_body(8'h01, 1'b1);

        drain_tx();
        cfg_write(rfpc_pkg::RegHeader, 8'h00, 1'b1);
        cfg_write(rfpc_pkg::RegTail, 8'hFF, 1'b1);
        cfg_write(RegUnusedLo, 8'h5A, 1'b1);
        cfg_write(RegUnusedHi, 8'hC3, 1'b0);
        send_body(8'hFF, 1'b1);
        send_body(8'h7E, 1'b0);
        send_body(8'h00, 1'b1);

        drain_tx();
        cfg_write(rfpc_pkg::RegHeader, 8'hFF, 1'b1);
        cfg_write(rfpc_pkg::RegTail, 8'h00, 1'b0);
        send_body(8'h55, 1'b0);
        send_body(8'hAA, 1'b1);

        // registers rewritten with a frame open
        send_body(8'h12, 1'b0);
        drain_tx();
        cfg_write(rfpc_pkg::RegTail, 8'h3C, 1'b1);
        cfg_write(rfpc_pkg::RegHeader, 8'h0F, 1'b0);
        send_body(8'h34, 1'b1);
        send_body(8'h01, 1'b1);

        // one long all-ones frame
        drain_tx();
        cfg_write(rfpc_pkg::RegHeader, 8'hFF, 1'b0);
        for (int i = 0; i < 20; i++)
        begin
            send_body(8'hFF, i == 19);
        end

        for (int p = 0; p < 6; p++)
        begin
            drain_tx();
            case (p)
                0:
                begin
                    cfg_write(rfpc_pkg::RegHeader, 8'h00, 1'b1);
                    cfg_write(rfpc_pkg::RegTail, 8'hFF, 1'b1);
                end
                1:
                begin
                    cfg_write(rfpc_pkg::RegHeader, 8'hFF, 1'b1);
                    cfg_write(rfpc_pkg::RegTail, 8'h00, 1'b1);
                end
                5:
                begin
                    cfg_write(rfpc_pkg::RegHeader, rfpc_pkg::HeaderReset, 1'b1);
                    cfg_write(rfpc_pkg::RegTail, rfpc_pkg::TailReset, 1'b1);
                end
                default:
                begin
                    cfg_write(rfpc_pkg::RegHeader, rfpc_pkg::ByteW'($urandom), 1'b1);
                    cfg_write(rfpc_pkg::RegTail, rfpc_pkg::ByteW'($urandom), 1'b1);
                end
            endcase
            cfg_write(rfpc_pkg::CfgIdxW'($urandom_range(RegUnusedLo, RegUnusedHi)),
                      rfpc_pkg::ByteW'($urandom), 1'b0);
            sent = 0;
            while (sent < 36)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 6);
                send_frame(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : 0);
                sent += len;
                if ($urandom_range(0, 11) == 0)
                begin
                    drain_tx();
                end
            end
        end

        drain_tx();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_tx_q.size() == 0)
        begin
            $display("[response_framer_popcount_checksum] OK");
        end
        else
        begin
            $display("[response_framer_popcount_checksum] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rfpc_pkg.sv
hdl/rfpc_body_if.sv
hdl/rfpc_tx_if.sv
hdl/rfpc_cfg_if.sv
hdl/rfpc_intake.sv
hdl/rfpc_emit.sv
hdl/response_framer_popcount_checksum.sv
sim/tb_top.sv
